// ===== hw/rtl/pacr_pkg.sv =====
package pacr_pkg;

    localparam int MAX_RAMP_STEPS_DEF = 15;
    localparam int DIV_BITS = 36;
    localparam int DEN_BITS = 20;

    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_LEVEL     = 3'd1;
    localparam logic [2:0] CFG_FACTOR    = 3'd2;
    localparam logic [2:0] CFG_MIN_RIDER = 3'd3;
    localparam logic [2:0] CFG_MAX_POWER = 3'd4;
    localparam logic [2:0] CFG_CUR_LIM   = 3'd5;
    localparam logic [2:0] CFG_RAMP      = 3'd6;
    localparam logic [2:0] CFG_TEMP      = 3'd7;

    localparam logic [15:0] POWER_SAT   = 16'hFFFF;
    localparam logic [15:0] POWER_FLOOR = 16'd10;
    localparam logic [19:0] MV_FLOOR    = 20'd10;
    localparam logic [19:0] MV_CEIL     = 20'd1000000;
    localparam logic [19:0] UW_PER_MW   = 20'd1000000;

    typedef struct packed {
        logic [15:0]        rider_power;
        logic [19:0]        bus_voltage_mv;
        logic signed [7:0]  motor_temp;
        logic signed [7:0]  controller_temp;
    } t_in;

    typedef struct packed {
        logic [15:0] current_ma;
        logic        ramp_step;
        logic        over_temp_stop;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        assist_mode;
        logic [7:0]  assist_level;
        logic [15:0] assist_factor;
        logic [15:0] min_rider_power;
        logic [15:0] max_assist_power;
        logic [31:0] current_limits;
        logic [21:0] ramp_setup;
        logic [15:0] temp_limits;
    } t_cfg;

    typedef struct packed {
        logic [15:0] power;
        logic [19:0] mv;
        logic        hot;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qctl;

endpackage

// ===== hw/rtl/pacr_front.sv =====
module pacr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pacr_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  pacr_pkg::t_in  i_data,
    input  logic           i_q_full,
    output logic           o_push,
    output pacr_pkg::t_job o_job
);
    import pacr_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL1, F_MUL2, F_PUSH} t_fstate;

    t_fstate     r_state;
    logic [15:0] r_rider;
    logic [19:0] r_mv;
    logic        r_hot;
    logic [23:0] r_p1;
    logic [39:0] r_p2;
    logic        drop;
    logic        hot_m;
    logic        hot_c;
    logic [15:0] sat;
    logic [15:0] pwr;

    assign hot_m = (i_cfg.temp_limits[7:0] != 8'd0) &&
        ($signed({1'b0, i_cfg.temp_limits[7:0]}) <=
         $signed({i_data.motor_temp[7], i_data.motor_temp}));
    assign hot_c = (i_cfg.temp_limits[15:8] != 8'd0) &&
        ($signed({1'b0, i_cfg.temp_limits[15:8]}) <=
         $signed({i_data.controller_temp[7], i_data.controller_temp}));
    assign drop = (i_cfg.assist_level == 8'd0) ||
                  (i_data.rider_power < i_cfg.min_rider_power) ||
                  (i_data.bus_voltage_mv <= MV_FLOOR) ||
                  (i_data.bus_voltage_mv > MV_CEIL);

    always_comb begin
        sat = (r_p2 > 40'(POWER_SAT)) ? POWER_SAT : r_p2[15:0];
        if (r_hot) begin
            sat = 16'd0;
        end
        pwr = (sat > i_cfg.max_assist_power) ? i_cfg.max_assist_power : sat;
    end

    assign o_ready    = (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_q_full;
    assign o_job.power = pwr;
    assign o_job.mv    = r_mv;
    assign o_job.hot   = r_hot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid && !drop) begin
                        r_state <= F_MUL1;
                    end
                end
                F_MUL1:  r_state <= F_MUL2;
                F_MUL2:  r_state <= F_PUSH;
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_rider <= i_data.rider_power;
            r_mv    <= i_data.bus_voltage_mv;
            r_hot   <= hot_m || hot_c;
        end
        if (r_state == F_MUL1) begin
            r_p1 <= 24'(i_cfg.assist_mode ? 16'd1 : r_rider) * 24'(i_cfg.assist_level);
        end
        if (r_state == F_MUL2) begin
            r_p2 <= 40'(r_p1) * 40'(i_cfg.assist_factor);
        end
    end

endmodule

// ===== hw/rtl/pacr_queue.sv =====
module pacr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pacr_pkg::t_job  i_job,
    input  logic            i_pop,
    output pacr_pkg::t_job  o_job,
    output pacr_pkg::t_qctl o_stat
);

    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    pacr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_we    (i_push),
        .i_waddr (r_wp),
        .i_job   (i_job),
        .i_raddr (r_rp),
        .o_job   (o_job)
    );

endmodule

// ===== hw/rtl/pacr_fifo.sv =====
module pacr_fifo (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic           i_waddr,
    input  pacr_pkg::t_job i_job,
    input  logic           i_raddr,
    output pacr_pkg::t_job o_job
);
    import pacr_pkg::*;

    t_job r_mem [2];

    assign o_job = r_mem[i_raddr];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_job;
        end
    end

endmodule

// ===== hw/rtl/pacr_div.sv =====
module pacr_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pacr_pkg::DIV_BITS-1:0]      i_dividend,
    input  logic [pacr_pkg::DEN_BITS-1:0]      i_divisor,
    output logic                               o_done,
    output logic [pacr_pkg::DIV_BITS-1:0]      o_quot
);
    import pacr_pkg::*;

    logic [DIV_BITS-1:0] r_quot;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [5:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS:0]   trial;
    logic                ge;
    logic [DEN_BITS:0]   diff;

    assign trial = {r_rem, r_quot[DIV_BITS-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_BITS-2:0], ge};
            r_rem  <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        end
    end

endmodule

// ===== hw/rtl/pacr_back.sv =====
module pacr_back #(
    parameter int MAX_RAMP_STEPS = pacr_pkg::MAX_RAMP_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pacr_pkg::t_cfg i_cfg,
    input  pacr_pkg::t_job i_job,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output pacr_pkg::t_out o_data
);
    import pacr_pkg::*;

    localparam logic [3:0] STEPS_CAP = (MAX_RAMP_STEPS > 15) ? 4'd15 : 4'(MAX_RAMP_STEPS);

    typedef enum logic [2:0] {
        B_IDLE, B_MUL, B_START, B_WAIT, B_CLAMP, B_RMUL, B_EMIT
    } t_bstate;

    t_bstate             r_state;
    t_job                r_job;
    logic [DIV_BITS-1:0] r_num;
    logic                r_ramping;
    logic [15:0]         r_prev;
    logic [15:0]         r_cur;
    logic [15:0]         r_lo;
    logic [15:0]         r_d;
    logic                r_neg;
    logic [3:0]          r_i;
    logic [3:0]          r_k;
    logic [3:0]          r_steps;
    logic                r_up;
    logic                r_final;
    t_out                r_out;
    logic                r_valid;

    logic                div_done;
    logic [DIV_BITS-1:0] quot;
    logic [DEN_BITS-1:0] den;
    logic [15:0]         min_c;
    logic [15:0]         max_c;
    logic [3:0]          steps;
    logic [15:0]         cur;
    logic [15:0]         diff;
    logic [15:0]         base;
    logic                ramp_ok;

    assign min_c = i_cfg.current_limits[15:0];
    assign max_c = i_cfg.current_limits[31:16];
    assign steps = (i_cfg.ramp_setup[3:0] > STEPS_CAP) ? STEPS_CAP : i_cfg.ramp_setup[3:0];
    assign den   = r_ramping ? {16'd0, r_steps} : r_job.mv;
    assign base  = (r_prev < min_c) ? min_c : r_prev;

    always_comb begin
        if (r_job.power <= POWER_FLOOR) begin
            cur = 16'd0;
        end else if (quot < DIV_BITS'(min_c)) begin
            cur = min_c;
        end else if (quot > DIV_BITS'(max_c)) begin
            cur = max_c;
        end else begin
            cur = quot[15:0];
        end
        diff = (r_cur > r_prev) ? r_cur - r_prev : r_prev - r_cur;
        ramp_ok = (r_cur != 16'd0) && (steps != 4'd0) &&
                  (i_cfg.ramp_setup[21:6] <= diff);
    end

    pacr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == B_START),
        .i_dividend (r_num),
        .i_divisor  (den),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign o_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_prev  <= 16'd0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL:   r_state <= B_START;
                B_START: r_state <= B_WAIT;
                B_WAIT: begin
                    if (div_done) begin
                        if (r_ramping) begin
                            r_valid <= 1'b1;
                            r_state <= B_EMIT;
                        end else begin
                            r_state <= B_CLAMP;
                        end
                    end
                end
                B_CLAMP: begin
                    if (ramp_ok && ((i_cfg.ramp_setup[4] && r_prev < r_cur) ||
                                    (i_cfg.ramp_setup[5] && r_cur < r_prev))) begin
                        r_state <= B_RMUL;
                    end else begin
                        r_valid <= 1'b1;
                        r_prev  <= r_cur;
                        r_state <= B_EMIT;
                    end
                end
                B_RMUL:  r_state <= B_START;
                B_EMIT: begin
                    if (i_ready) begin
                        if (r_final) begin
                            r_valid <= 1'b0;
                            r_state <= B_IDLE;
                        end else if (r_k == 4'd1) begin
                            r_prev  <= r_cur;
                        end else begin
                            r_valid <= 1'b0;
                            r_state <= B_RMUL;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job     <= i_job;
                r_ramping <= 1'b0;
            end
            B_MUL: begin
                r_num <= DIV_BITS'(r_job.power) * DIV_BITS'(UW_PER_MW);
            end
            B_WAIT: begin
                if (div_done && !r_ramping) begin
                    r_cur <= cur;
                end
                if (div_done && r_ramping) begin
                    r_out.current_ma     <= r_neg ? r_lo - quot[15:0] : r_lo + quot[15:0];
                    r_out.ramp_step      <= 1'b1;
                    r_out.over_temp_stop <= 1'b0;
                    r_out.last           <= 1'b0;
                    r_final              <= 1'b0;
                end
            end
            B_CLAMP: begin
                r_steps   <= steps;
                r_k       <= steps;
                r_ramping <= 1'b1;
                if (i_cfg.ramp_setup[4] && r_prev < r_cur) begin
                    r_up  <= 1'b1;
                    r_lo  <= base;
                    r_neg <= (base > r_cur);
                    r_d   <= (base > r_cur) ? base - r_cur : r_cur - base;
                    r_i   <= 4'd0;
                end else begin
                    r_up  <= 1'b0;
                    r_lo  <= r_cur;
                    r_neg <= 1'b0;
                    r_d   <= r_prev - r_cur;
                    r_i   <= steps;
                end
                r_out.current_ma     <= r_cur;
                r_out.ramp_step      <= 1'b0;
                r_out.over_temp_stop <= r_job.hot;
                r_out.last           <= 1'b1;
                r_final              <= 1'b1;
            end
            B_RMUL: begin
                r_num <= DIV_BITS'(r_d) * DIV_BITS'(r_i);
            end
            B_EMIT: begin
                if (i_ready && !r_final) begin
                    r_k <= r_k - 4'd1;
                    r_i <= r_up ? r_i + 4'd1 : r_i - 4'd1;
                    if (r_k == 4'd1) begin
                        r_out.current_ma     <= r_cur;
                        r_out.ramp_step      <= 1'b0;
                        r_out.over_temp_stop <= r_job.hot;
                        r_out.last           <= 1'b1;
                        r_final              <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/pedal_assist_current_ramp.sv =====
// channel | valid      | ready       | payload
// input   | i_in_valid | o_in_ready  | i_in_data  (t_in)
// result  | o_out_valid| i_out_ready | o_out_data (t_out)
// config  | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
// Front: each input word passes two multiplier stages (F_MUL1, F_MUL2), then a 2-deep queue.
// Back: the final current comes from a 36-bit shift-subtract divider, and each ramp word
// passes through the same divider.
// Reset clears control state and previous current and loads configuration defaults.
// Either side stalls on its own; a held result word blocks the back part, and the front once the queue is full.
module pedal_assist_current_ramp #(
    parameter int MAX_RAMP_STEPS = pacr_pkg::MAX_RAMP_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pacr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pacr_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import pacr_pkg::*;

    t_cfg  r_cfg;
    t_job  f_job;
    t_job  q_job;
    t_qctl q_stat;
    logic  push;
    logic  pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.assist_mode      <= 1'b0;
            r_cfg.assist_level     <= 8'd0;
            r_cfg.assist_factor    <= 16'd0;
            r_cfg.min_rider_power  <= 16'd0;
            r_cfg.max_assist_power <= 16'hFFFF;
            r_cfg.current_limits   <= 32'hFFFF0000;
            r_cfg.ramp_setup       <= 22'd0;
            r_cfg.temp_limits      <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:      r_cfg.assist_mode      <= i_cfg_data[0];
                CFG_LEVEL:     r_cfg.assist_level     <= i_cfg_data[7:0];
                CFG_FACTOR:    r_cfg.assist_factor    <= i_cfg_data[15:0];
                CFG_MIN_RIDER: r_cfg.min_rider_power  <= i_cfg_data[15:0];
                CFG_MAX_POWER: r_cfg.max_assist_power <= i_cfg_data[15:0];
                CFG_CUR_LIM:   r_cfg.current_limits   <= i_cfg_data;
                CFG_RAMP:      r_cfg.ramp_setup       <= i_cfg_data[21:0];
                CFG_TEMP:      r_cfg.temp_limits      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    pacr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_data   (i_in_data),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_job    (f_job)
    );

    pacr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    pacr_back #(
        .MAX_RAMP_STEPS (MAX_RAMP_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_job     (q_job),
        .i_q_empty (q_stat.empty),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule
